// ----- sv/priority_retaining_event_log_assert.svh -----
`ifndef PRIORITY_RETAINING_EVENT_LOG_ASSERT_SVH
`define PRIORITY_RETAINING_EVENT_LOG_ASSERT_SVH
// Assertion helpers used by the log controller.
`define PREL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PREL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- sv/prel_pkg.sv -----
package prel_pkg;
    localparam int LOG_DEPTH = 64;
    localparam int IDX_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = 7;
    localparam int ENTRY_W = 32 + 64 + 5 + 32;
    localparam logic [2:0] NUM_CATEGORIES = 3'd6;
    localparam logic [1:0] SEV_CRITICAL = 2'd3;

    localparam logic [1:0] OP_APPEND_AUTO = 2'd0;
    localparam logic [1:0] OP_APPEND_EXPL = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_CATEGORY = 2'd1;
    localparam logic [1:0] ST_BAD_SEQUENCE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] tick;
        logic [2:0]  category;
        logic [1:0]  severity;
        logic [31:0] payload;
        logic [63:0] explicit_seq;
        logic        use_category;
        logic        use_severity;
        logic [6:0]  match_limit;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        event_valid;
        logic [31:0] out_tick;
        logic [63:0] out_seq;
        logic [2:0]  out_category;
        logic [1:0]  out_severity;
        logic [31:0] out_payload;
        logic        last;
        logic [6:0]  stored_count;
        logic [6:0]  critical_held;
        logic [63:0] next_seq_out;
    } out_word_t;

    typedef struct packed {
        logic [31:0] tick;
        logic [63:0] seq;
        logic [2:0]  category;
        logic [1:0]  severity;
        logic [31:0] tag;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic       wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic       wr_new;
        logic       commit_append;
        logic       evict_critical;
        logic       evict_en;
        logic       hold_entry;
        logic       emit_entry;
        logic [1:0] emit_status;
        logic       emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        in_word_t   item;
        entry_t     rd_entry;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] capacity;
        logic [63:0] seq_head;
    } dp_stat_t;
endpackage

// ----- sv/prel_if.sv -----
interface prel_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/prel_ram.sv -----
module prel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- sv/prel_datapath.sv -----
module prel_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  prel_pkg::in_word_t  in_data,
    input  prel_pkg::dp_cmd_t   cmd,
    output prel_pkg::dp_stat_t  stat,
    output prel_pkg::out_word_t out_word
);
    import prel_pkg::*;

    in_word_t         item_reg;
    entry_t           entry_hold_reg;
    logic [6:0]       cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] crit_reg;
    logic [63:0]      nseq_reg;
    entry_t           rd_entry;
    entry_t           new_entry;
    entry_t           wr_entry;
    logic [63:0]      seq_sel;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] crit_next;

    assign seq_sel = (item_reg.op == OP_APPEND_EXPL) ? item_reg.explicit_seq : nseq_reg;
    assign new_entry = '{tick: item_reg.tick, seq: seq_sel, category: item_reg.category,
                         severity: item_reg.severity, tag: item_reg.payload};
    assign wr_entry = cmd.wr_new ? new_entry : rd_entry;

    prel_ram #(.WIDTH(ENTRY_W), .DEPTH(LOG_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        cap_eff = cap_reg;
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(LOG_DEPTH))
        begin
            cap_eff = CNT_W'(LOG_DEPTH);
        end
        count_next = count_reg;
        crit_next = crit_reg;
        if (cmd.evict_en)
        begin
            count_next = count_next - CNT_W'(1);
            if (cmd.evict_critical && crit_next != '0)
            begin
                crit_next = crit_next - CNT_W'(1);
            end
        end
        if (cmd.commit_append)
        begin
            count_next = count_next + CNT_W'(1);
            if (item_reg.severity == SEV_CRITICAL)
            begin
                crit_next = crit_next + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 7'd64;
            count_reg <= '0;
            crit_reg  <= '0;
            nseq_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            crit_reg  <= crit_next;
            if (cmd.commit_append)
            begin
                nseq_reg <= seq_sel + 64'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.hold_entry)
        begin
            entry_hold_reg <= rd_entry;
        end
    end

    always_comb
    begin
        out_word = '0;
        out_word.status = cmd.emit_status;
        out_word.last = cmd.emit_last;
        out_word.stored_count = count_reg;
        out_word.critical_held = crit_reg;
        out_word.next_seq_out = nseq_reg;
        if (cmd.emit_entry)
        begin
            out_word.event_valid = 1'b1;
            out_word.out_tick = entry_hold_reg.tick;
            out_word.out_seq = entry_hold_reg.seq;
            out_word.out_category = entry_hold_reg.category;
            out_word.out_severity = entry_hold_reg.severity;
            out_word.out_payload = entry_hold_reg.tag;
        end
    end

    assign stat = '{item: item_reg, rd_entry: rd_entry, count: count_reg,
                    capacity: cap_eff, seq_head: nseq_reg};
endmodule

// ----- sv/prel_ctrl.sv -----
module prel_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output prel_pkg::dp_cmd_t  cmd,
    input  prel_pkg::dp_stat_t stat
);
    import prel_pkg::*;
    `include "priority_retaining_event_log_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SEARCH, S_SHIFT, S_QUERY, S_RESULT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W:0]   idx_reg, idx_next;
    logic [IDX_W:0]   victim_reg, victim_next;
    logic [CNT_W-1:0] nmatch_reg, nmatch_next;
    logic             pend_reg, pend_next;
    logic             qdone_reg, qdone_next;
    logic             held_reg, held_next;
    logic [1:0]       rstat_reg, rstat_next;
    logic             rentry_reg, rentry_next;
    logic             rlast_reg, rlast_next;
    logic             shift_wr_reg, shift_wr_next;
    logic             match;
    logic [IDX_W:0]   cnt_ext;
    logic             full;

    assign cnt_ext = (IDX_W+1)'(stat.count);
    assign full = (stat.count >= stat.capacity);
    assign match = (!stat.item.use_category || stat.rd_entry.category == stat.item.category)
                && (!stat.item.use_severity || stat.rd_entry.severity >= stat.item.severity);

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        victim_next = victim_reg;
        nmatch_next = nmatch_reg;
        pend_next = 1'b0;
        qdone_next = qdone_reg;
        held_next = held_reg;
        rstat_next = rstat_reg;
        rentry_next = rentry_reg;
        rlast_next = rlast_reg;
        shift_wr_next = 1'b0;
        cmd = '0;
        cmd.emit_status = rstat_reg;
        cmd.emit_entry = rentry_reg;
        cmd.emit_last = rlast_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rstat_next = ST_OK;
                rentry_next = 1'b0;
                rlast_next = 1'b1;
                idx_next = '0;
                victim_next = '0;
                nmatch_next = '0;
                qdone_next = 1'b0;
                held_next = 1'b0;
                if (stat.item.op == OP_APPEND_AUTO || stat.item.op == OP_APPEND_EXPL)
                begin
                    if (stat.item.category >= NUM_CATEGORIES)
                    begin
                        rstat_next = ST_BAD_CATEGORY;
                        state_next = S_RESULT;
                    end
                    else if (stat.item.op == OP_APPEND_EXPL
                             && stat.item.explicit_seq < stat.seq_head)
                    begin
                        rstat_next = ST_BAD_SEQUENCE;
                        state_next = S_RESULT;
                    end
                    else if (full && stat.count != '0)
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = '0;
                        pend_next = 1'b1;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                        cmd.wr_new = 1'b1;
                        cmd.wr_addr = stat.count[IDX_W-1:0];
                        cmd.commit_append = 1'b1;
                        state_next = S_RESULT;
                    end
                end
                else if (stat.item.op == OP_QUERY)
                begin
                    if (stat.count == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = '0;
                        pend_next = 1'b1;
                        state_next = S_QUERY;
                    end
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SEARCH:
            begin
                // One entry per cycle; the read data of idx_reg arrives now.
                if (stat.rd_entry.severity != SEV_CRITICAL)
                begin
                    victim_next = idx_reg;
                end
                if (stat.rd_entry.severity != SEV_CRITICAL
                    || idx_reg + 1'b1 >= cnt_ext)
                begin
                    cmd.evict_en = 1'b1;
                    cmd.evict_critical = (stat.rd_entry.severity == SEV_CRITICAL);
                    if (stat.rd_entry.severity == SEV_CRITICAL)
                    begin
                        victim_next = '0;
                    end
                    idx_next = (stat.rd_entry.severity != SEV_CRITICAL) ? idx_reg + 1'b1
                                                                        : (IDX_W+1)'(1);
                    if (idx_next >= cnt_ext)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = idx_next[IDX_W-1:0];
                        shift_wr_next = 1'b1;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = idx_next[IDX_W-1:0];
                end
            end
            S_SHIFT:
            begin
                // Entry idx_reg moves down one slot; count was lowered on eviction.
                if (shift_wr_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = idx_reg[IDX_W-1:0] - 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_next <= cnt_ext)
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = idx_next[IDX_W-1:0];
                        shift_wr_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_new = 1'b1;
                    cmd.wr_addr = stat.count[IDX_W-1:0];
                    cmd.commit_append = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_QUERY:
            begin
                // A match is held until the next one is found, so the final word is known.
                if (pend_reg)
                begin
                    if (match && !held_reg)
                    begin
                        nmatch_next = nmatch_reg + 1'b1;
                        cmd.hold_entry = 1'b1;
                        if ((idx_reg + 1'b1 >= cnt_ext)
                            || (stat.item.match_limit != '0
                                && nmatch_next >= stat.item.match_limit))
                        begin
                            rentry_next = 1'b1;
                            rlast_next = 1'b1;
                            qdone_next = 1'b1;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            held_next = 1'b1;
                            idx_next = idx_reg + 1'b1;
                            cmd.rd_en = 1'b1;
                            cmd.rd_addr = idx_next[IDX_W-1:0];
                            pend_next = 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        held_next = 1'b0;
                        rentry_next = 1'b1;
                        rlast_next = 1'b0;
                        state_next = S_RESULT;
                    end
                    else if (idx_reg + 1'b1 >= cnt_ext)
                    begin
                        held_next = 1'b0;
                        rentry_next = held_reg;
                        rlast_next = 1'b1;
                        qdone_next = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = idx_next[IDX_W-1:0];
                        pend_next = 1'b1;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    if (stat.item.op == OP_QUERY && rentry_reg && !qdone_reg)
                    begin
                        // The entry at idx_reg matched and is read again.
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = idx_reg[IDX_W-1:0];
                        pend_next = 1'b1;
                        state_next = S_QUERY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            victim_reg   <= '0;
            nmatch_reg   <= '0;
            pend_reg     <= 1'b0;
            qdone_reg    <= 1'b0;
            held_reg     <= 1'b0;
            rstat_reg    <= ST_OK;
            rentry_reg   <= 1'b0;
            rlast_reg    <= 1'b0;
            shift_wr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            victim_reg   <= victim_next;
            nmatch_reg   <= nmatch_next;
            pend_reg     <= pend_next;
            qdone_reg    <= qdone_next;
            held_reg     <= held_next;
            rstat_reg    <= rstat_next;
            rentry_reg   <= rentry_next;
            rlast_reg    <= rlast_next;
            shift_wr_reg <= shift_wr_next;
        end
    end

    `PREL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, stat.count <= CNT_W'(LOG_DEPTH))
    `PREL_ASSERT_IMPL(a_reject_last, clk, rst_n,
        out_valid && rstat_reg != ST_OK, rlast_reg && !rentry_reg)
    `PREL_ASSERT_NEXT(a_accept_decode, clk, rst_n,
        in_valid && in_ready, state_reg == S_DECODE)
    `PREL_ASSERT_IMPL(a_victim_range, clk, rst_n,
        state_reg == S_SHIFT, victim_reg <= cnt_ext)
endmodule

// ----- sv/priority_retaining_event_log.sv -----
// Bounded event log of up to 64 entries held in one RAM in sequence order.
// Words are taken one at a time; the input is ready only while the block is idle.
// A rejected append, a non-full append or an unused op goes from decode straight
// to the result. A full append scans for the oldest non-critical entry, or evicts
// the oldest entry when every entry is critical, and then moves every younger
// entry down one slot, one RAM access per cycle. A query scans one entry per
// cycle, pausing while each returned word is offered, and holds each match until
// the next one is found, so that the final word can be marked. An output stall
// holds the result word until it is taken.
// The capacity register may be written only while no word is in flight.
module priority_retaining_event_log (
    input  logic       clk,
    input  logic       rst_n,
    prel_if.sink       in_ch,
    prel_if.source     out_ch,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata
);
    import prel_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    prel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    prel_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_ch.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_ch.data)
    );
endmodule

// ----- test/prel_tb_pkg.sv -----
`timescale 1ns / 1ps
package prel_tb_pkg;
    import prel_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import prel_pkg::*;
    import prel_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    prel_if #(.payload_t(in_word_t)) in_ch ();
    prel_if #(.payload_t(out_word_t)) out_ch ();

    priority_retaining_event_log u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    entry_t log_store[$];
    logic [6:0] capacity_reg;
    int unsigned model_crit_total;
    logic [63:0] model_seq_head;
    out_word_t expected_words[$];

    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;
    int hold_cycles;
    int errors;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic out_word_t blank_word(logic [1:0] status, logic is_last);
        out_word_t w;
        w = '0;
        w.status = status;
        w.last = is_last;
        w.stored_count = 7'(log_store.size());
        w.critical_held = 7'(model_crit_total);
        w.next_seq_out = model_seq_head;
        return w;
    endfunction

    function automatic int unsigned effective_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c < 1) c = 1;
        if (c > LOG_DEPTH) c = LOG_DEPTH;
        return c;
    endfunction

    task automatic expect_word(input out_word_t w);
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic evict_oldest();
        int victim;
        victim = 0;
        foreach (log_store[i])
        begin
            if (log_store[i].severity != SEV_CRITICAL)
            begin
                victim = i;
                break;
            end
        end
        if (log_store[victim].severity == SEV_CRITICAL && model_crit_total > 0)
            model_crit_total--;
        log_store.delete(victim);
    endtask

    task automatic predict_log(input in_word_t w);
        logic [63:0] seq;
        entry_t e;
        int n;
        out_word_t r;
        if (w.op == OP_APPEND_AUTO || w.op == OP_APPEND_EXPL)
        begin
            seq = (w.op == OP_APPEND_EXPL) ? w.explicit_seq : model_seq_head;
            if (w.category >= NUM_CATEGORIES)
                expect_word(blank_word(ST_BAD_CATEGORY, 1'b1));
            else if (seq < model_seq_head)
                expect_word(blank_word(ST_BAD_SEQUENCE, 1'b1));
            else
            begin
                if (log_store.size() >= effective_capacity() && log_store.size() > 0)
                    evict_oldest();
                e.tick = w.tick;
                e.seq = seq;
                e.category = w.category;
                e.severity = w.severity;
                e.tag = w.payload;
                log_store.insert(log_store.size(), e);
                if (w.severity == SEV_CRITICAL) model_crit_total++;
                model_seq_head = seq + 64'd1;
                expect_word(blank_word(ST_OK, 1'b1));
            end
        end
        else if (w.op == OP_QUERY)
        begin
            n = 0;
            foreach (log_store[i])
            begin
                if (w.use_category && log_store[i].category != w.category) continue;
                if (w.use_severity && log_store[i].severity < w.severity) continue;
                r = blank_word(ST_OK, 1'b0);
                r.event_valid = 1'b1;
                r.out_tick = log_store[i].tick;
                r.out_seq = log_store[i].seq;
                r.out_category = log_store[i].category;
                r.out_severity = log_store[i].severity;
                r.out_payload = log_store[i].tag;
                expect_word(r);
                n++;
                if (w.match_limit != 0 && n >= w.match_limit) break;
            end
            if (n == 0)
                expect_word(blank_word(ST_OK, 1'b1));
            else
                expected_words[expected_words.size() - 1].last = 1'b1;
        end
        else
            expect_word(blank_word(ST_OK, 1'b1));
    endtask

    task automatic send_word(input in_word_t w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        predict_log(w);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (3 + 2 * LOG_DEPTH) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [6:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        capacity_reg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic in_word_t random_word();
        in_word_t w;
        int r;
        w.tick = $urandom;
        w.payload = $urandom;
        w.explicit_seq = {$urandom, $urandom};
        w.use_category = 1'($urandom_range(1));
        w.use_severity = 1'($urandom_range(1));
        w.match_limit = $urandom_range(3) == 0 ? 7'($urandom_range(127))
                                               : 7'($urandom_range(4));
        w.severity = 2'($urandom_range(3));
        w.category = $urandom_range(9) == 0 ? 3'($urandom_range(7, 6))
                                            : 3'($urandom_range(5));
        r = $urandom_range(99);
        if (r < 45) w.op = OP_APPEND_AUTO;
        else if (r < 65)
        begin
            w.op = OP_APPEND_EXPL;
            case ($urandom_range(3))
                0: w.explicit_seq = model_seq_head + $urandom_range(5);
                1: w.explicit_seq = model_seq_head - $urandom_range(3);
                2: w.explicit_seq = model_seq_head + {$urandom_range(1), $urandom};
                default: ;
            endcase
        end
        else if (r < 97) w.op = OP_QUERY;
        else w.op = OP_UNUSED;
        return w;
    endfunction

    function automatic in_word_t make_word(logic [1:0] op, logic [2:0] cat,
                                           logic [1:0] sev, logic [63:0] seq);
        in_word_t w;
        w = '0;
        w.op = op;
        w.category = cat;
        w.severity = sev;
        w.explicit_seq = seq;
        w.tick = $urandom;
        w.payload = $urandom;
        return w;
    endfunction

    task automatic test_directed();
        in_word_t w;
        send_word(make_word(OP_QUERY, 3'd0, 2'd0, 64'd0));
        w = make_word(OP_APPEND_AUTO, 3'd0, 2'd0, 64'd0);
        w.tick = '0;
        w.payload = '0;
        send_word(w);
        w = make_word(OP_APPEND_AUTO, 3'd5, SEV_CRITICAL, 64'd0);
        w.tick = '1;
        w.payload = '1;
        send_word(w);
        send_word(make_word(OP_APPEND_AUTO, 3'd6, 2'd1, 64'd0));
        send_word(make_word(OP_APPEND_EXPL, 3'd7, 2'd2, 64'd100));
        send_word(make_word(OP_APPEND_EXPL, 3'd2, 2'd2, 64'd0));
        send_word(make_word(OP_APPEND_EXPL, 3'd3, 2'd1, 64'h7fff_ffff_ffff_ffff));
        send_word(make_word(OP_APPEND_EXPL, 3'd4, SEV_CRITICAL, '1));
        send_word(make_word(OP_APPEND_AUTO, 3'd1, 2'd2, 64'd0));
        send_word(make_word(OP_UNUSED, 3'd1, 2'd2, 64'd0));
        w = make_word(OP_QUERY, 3'd7, 2'd0, 64'd0);
        w.use_category = 1'b1;
        send_word(w);
        w = make_word(OP_QUERY, 3'd5, SEV_CRITICAL, 64'd0);
        w.use_severity = 1'b1;
        send_word(w);
        w = make_word(OP_QUERY, 3'd1, 2'd0, 64'd0);
        w.use_category = 1'b1;
        w.use_severity = 1'b1;
        w.match_limit = 7'd64;
        send_word(w);
        w = make_word(OP_QUERY, 3'd0, 2'd0, 64'd0);
        w.match_limit = 7'd1;
        send_word(w);
        w.match_limit = 7'd127;
        send_word(w);
    endtask

    task automatic test_capacity_eviction();
        write_capacity(7'd3);
        send_word(make_word(OP_APPEND_AUTO, 3'd0, SEV_CRITICAL, 64'd0));
        send_word(make_word(OP_APPEND_AUTO, 3'd1, SEV_CRITICAL, 64'd0));
        send_word(make_word(OP_APPEND_AUTO, 3'd2, 2'd1, 64'd0));
        send_word(make_word(OP_APPEND_AUTO, 3'd3, SEV_CRITICAL, 64'd0));
        send_word(make_word(OP_APPEND_AUTO, 3'd4, SEV_CRITICAL, 64'd0));
        send_word(make_word(OP_QUERY, 3'd0, 2'd0, 64'd0));
        write_capacity(7'd0);
        send_word(make_word(OP_APPEND_AUTO, 3'd5, 2'd0, 64'd0));
        send_word(make_word(OP_QUERY, 3'd0, 2'd0, 64'd0));
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_word(random_word());
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_random();
        write_capacity(7'd127);
        run_random(70, 0, 0);
        write_capacity(7'd5);
        run_random(50, 68, 0);
        write_capacity(7'd1);
        run_random(30, 0, 68);
        write_capacity(7'd64);
        run_random(90, 13, 13);
        write_capacity(7'd12);
        run_random(30, 0, 0);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        recv_hold = 1'b1;
        repeat (20) send_word(make_word(OP_APPEND_AUTO, 3'($urandom_range(5)),
                                        2'($urandom_range(3)), 64'd0));
        send_word(make_word(OP_QUERY, 3'd0, 2'd0, 64'd0));
    endtask

    always @(posedge clk)
    begin
        if (recv_hold)
        begin
            out_ch.ready <= 1'b0;
            if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
            else recv_hold <= 1'b0;
        end
        else
            out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %h", $time, out_ch.data);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (out_ch.data !== exp_w)
                begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, exp_w,
                             out_ch.data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        recv_hold = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        idle_cycles = 0;
        capacity_reg = 7'd64;
        model_crit_total = 0;
        model_seq_head = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity_eviction();
        test_random();
        test_backpressure();
        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/prel_pkg.sv
sv/prel_if.sv
sv/prel_ram.sv
sv/prel_datapath.sv
sv/prel_ctrl.sv
sv/priority_retaining_event_log.sv
test/prel_tb_pkg.sv
test/testbench.sv
